@@ design/lbes_pkg.sv @@
// ----------------------------------------------------------------------------
// lbes_pkg: shared types and codes of the lamp effect sequencer
// Effect and light mode codes, and the structs that pass configuration,
// sequencer state and one result between the modules.
// ----------------------------------------------------------------------------
package lbes_pkg;

  // Effect codes carried by a start transaction and held as the running effect.
  localparam logic [2:0] EFF_NONE   = 3'd0;
  localparam logic [2:0] EFF_FAST   = 3'd1;
  localparam logic [2:0] EFF_SLOW   = 3'd2;
  localparam logic [2:0] EFF_MODEB  = 3'd3;
  localparam logic [2:0] EFF_DELAY  = 3'd4;
  localparam logic [2:0] EFF_NORMAL = 3'd5;

  // Light mode codes.
  localparam logic [2:0] LM_MANUAL = 3'd0;
  localparam logic [2:0] LM_FRONT  = 3'd1;
  localparam logic [2:0] LM_REAR   = 3'd2;
  localparam logic [2:0] LM_BOTH   = 3'd3;

  // Input opcodes.
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // Elapsed time saturates at the top of its 17-bit range.
  localparam logic [16:0] ELAPSED_MAX = 17'h1FFFF;

  typedef struct packed {
    logic [2:0]  light_mode;
    logic        front_state;
    logic        rear_state;
    logic [15:0] tick_ms;
    logic [15:0] fast_period_ms;
    logic [15:0] slow_period_ms;
    logic [15:0] hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  effect_mode;
    logic [15:0] remaining_count;
    logic [16:0] elapsed_ms;
  } seq_state_t;

  typedef struct packed {
    logic front_write;
    logic front_level;
    logic rear_write;
    logic rear_level;
    logic active;
  } result_t;

endpackage

@@ design/lbes_cfg.sv @@
// ----------------------------------------------------------------------------
// lbes_cfg: configuration register file
// Holds the seven configuration registers; writes to unused indexes are
// dropped.
// ----------------------------------------------------------------------------
module lbes_cfg (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [15:0]     cfg_data,
  output lbes_pkg::cfg_t  cfg
);

  localparam logic [2:0] REG_LIGHT_MODE  = 3'd0;
  localparam logic [2:0] REG_FRONT_STATE = 3'd1;
  localparam logic [2:0] REG_REAR_STATE  = 3'd2;
  localparam logic [2:0] REG_TICK        = 3'd3;
  localparam logic [2:0] REG_FAST        = 3'd4;
  localparam logic [2:0] REG_SLOW        = 3'd5;
  localparam logic [2:0] REG_HOLD        = 3'd6;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.light_mode     <= lbes_pkg::LM_MANUAL;
      cfg.front_state    <= 1'b0;
      cfg.rear_state     <= 1'b0;
      cfg.tick_ms        <= 16'd50;
      cfg.fast_period_ms <= 16'd200;
      cfg.slow_period_ms <= 16'd1000;
      cfg.hold_ticks     <= 16'd100;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LIGHT_MODE:  cfg.light_mode     <= cfg_data[2:0];
        REG_FRONT_STATE: cfg.front_state    <= cfg_data[0];
        REG_REAR_STATE:  cfg.rear_state     <= cfg_data[0];
        REG_TICK:        cfg.tick_ms        <= cfg_data;
        REG_FAST:        cfg.fast_period_ms <= cfg_data;
        REG_SLOW:        cfg.slow_period_ms <= cfg_data;
        REG_HOLD:        cfg.hold_ticks     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

@@ design/lbes_step.sv @@
// ----------------------------------------------------------------------------
// lbes_step: next-state and result logic for one transaction
// Applies a start or tick transaction to the current sequencer state and
// produces the next state and the lamp writes.
// ----------------------------------------------------------------------------
module lbes_step (
  input  logic                   opcode,
  input  logic [2:0]             effect,
  input  logic [15:0]            blink_count,
  input  lbes_pkg::cfg_t         cfg,
  input  lbes_pkg::seq_state_t   cur,
  output lbes_pkg::seq_state_t   nxt,
  output lbes_pkg::result_t      res
);

  logic [17:0] sum;
  logic [16:0] sat;
  logic        man;
  logic [15:0] period;
  logic        reached;
  logic        react;

  always_comb begin
    sum  = {1'b0, cur.elapsed_ms} + {2'b00, cfg.tick_ms};
    sat  = sum[17] ? lbes_pkg::ELAPSED_MAX : sum[16:0];
    man  = (cfg.light_mode == lbes_pkg::LM_MANUAL);
    react = (cfg.light_mode == lbes_pkg::LM_FRONT) || (cfg.light_mode == lbes_pkg::LM_REAR) ||
            (cfg.light_mode == lbes_pkg::LM_BOTH);

    // Phase length of the running effect; the delayed-light count steps on tick_ms.
    case (cur.effect_mode)
      lbes_pkg::EFF_SLOW:  period = cfg.slow_period_ms;
      lbes_pkg::EFF_DELAY: period = cfg.tick_ms;
      default:             period = cfg.fast_period_ms;
    endcase
    reached = (sat >= {1'b0, period});

    nxt = cur;
    res = '0;

    if (opcode == lbes_pkg::OP_START) begin
      nxt.effect_mode     = effect;
      nxt.remaining_count = blink_count;
      nxt.elapsed_ms      = '0;
    end else if (cur.remaining_count != 16'd0) begin
      case (cur.effect_mode)
        lbes_pkg::EFF_FAST, lbes_pkg::EFF_SLOW, lbes_pkg::EFF_MODEB: begin
          nxt.elapsed_ms = sat;
          if (reached) begin
            res.front_write = 1'b1;
            res.rear_write  = 1'b1;
            if (cur.remaining_count[0]) begin
              if (cur.effect_mode == lbes_pkg::EFF_MODEB) begin
                // Mode blink lights the lamps named by the light mode.
                if ((man && cfg.front_state && !cfg.rear_state) ||
                    cfg.light_mode == lbes_pkg::LM_FRONT) begin
                  res.front_level = 1'b1;
                end else if ((man && !cfg.front_state && cfg.rear_state) ||
                             cfg.light_mode == lbes_pkg::LM_REAR) begin
                  res.rear_level = 1'b1;
                end else if ((man && cfg.front_state && cfg.rear_state) ||
                             cfg.light_mode == lbes_pkg::LM_BOTH) begin
                  res.front_level = 1'b1;
                  res.rear_level  = 1'b1;
                end else begin
                  res.front_write = 1'b0;
                  res.rear_write  = 1'b0;
                end
              end else begin
                res.rear_level = 1'b1;
              end
            end
            nxt.remaining_count = cur.remaining_count - 16'd1;
            nxt.elapsed_ms      = '0;
          end
        end
        lbes_pkg::EFF_DELAY: begin
          nxt.elapsed_ms = sat;
          if (reached) begin
            nxt.remaining_count = cur.remaining_count - 16'd1;
            nxt.elapsed_ms      = '0;
          end
        end
        default: ;
      endcase
    end else begin
      case (cur.effect_mode)
        lbes_pkg::EFF_FAST, lbes_pkg::EFF_SLOW, lbes_pkg::EFF_MODEB: begin
          nxt.elapsed_ms = sat;
          if (reached) begin
            nxt.effect_mode = lbes_pkg::EFF_NONE;
            nxt.elapsed_ms  = '0;
            if (cur.effect_mode == lbes_pkg::EFF_SLOW) begin
              res.front_write = 1'b1;
              res.rear_write  = 1'b1;
              res.rear_level  = 1'b1;
            end else if (man) begin
              // Restore the manual lamp states.
              res.front_write = cfg.front_state;
              res.front_level = cfg.front_state;
              res.rear_write  = cfg.rear_state;
              res.rear_level  = cfg.rear_state;
            end else if (cur.effect_mode == lbes_pkg::EFF_MODEB && react) begin
              nxt.effect_mode     = lbes_pkg::EFF_DELAY;
              nxt.remaining_count = cfg.hold_ticks;
            end
          end
        end
        lbes_pkg::EFF_DELAY: begin
          res.front_write = 1'b1;
          res.rear_write  = 1'b1;
          nxt.effect_mode = lbes_pkg::EFF_NONE;
          nxt.elapsed_ms  = '0;
        end
        lbes_pkg::EFF_NORMAL: begin
          nxt.effect_mode = lbes_pkg::EFF_NONE;
        end
        default: ;
      endcase
    end

    res.active = (opcode == lbes_pkg::OP_START) ||
                 (nxt.effect_mode != lbes_pkg::EFF_NONE) || (nxt.remaining_count != 16'd0);
  end

endmodule

@@ design/led_blink_effect_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// led_blink_effect_sequencer_unit: two-lamp blink effect sequencer
// Pipeline: the input register, then the result register.
// Throughput: one transaction per cycle unless the result channel stalls; the
//   state update is a single add, saturate and compare between the two registers.
// Reset: synchronous, active high; clears both pipeline valids and the effect
//   state, and loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
module led_blink_effect_sequencer_unit (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // Input channel.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [2:0]  effect,
  input  logic [15:0] blink_count,
  // Result channel.
  output logic        out_valid,
  input  logic        out_ready,
  output logic        front_write,
  output logic        front_level,
  output logic        rear_write,
  output logic        rear_level,
  output logic        active
);

  lbes_pkg::cfg_t       cfg;
  lbes_pkg::seq_state_t state;
  lbes_pkg::seq_state_t state_next;
  lbes_pkg::result_t    res;

  // Input register: holds one accepted transaction until the step logic can
  // retire it into the result register.
  logic        s1_valid;
  logic        s1_opcode;
  logic [2:0]  s1_effect;
  logic [15:0] s1_blink_count;
  logic        s1_go;

  // The step retires when the result register is empty or is being drained in
  // the same cycle. The input register refills whenever it empties or retires,
  // so a new transaction is taken while a finished result still waits.
  assign s1_go    = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_go;

  lbes_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lbes_step u_step (
    .opcode      (s1_opcode),
    .effect      (s1_effect),
    .blink_count (s1_blink_count),
    .cfg         (cfg),
    .cur         (state),
    .nxt         (state_next),
    .res         (res)
  );

  // Input register control and payload.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_opcode      <= opcode;
      s1_effect      <= effect;
      s1_blink_count <= blink_count;
    end
  end

  // Sequencer state advances exactly once per retired transaction, so the
  // next transaction in the input register always sees the updated state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (s1_go) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      front_write <= res.front_write;
      front_level <= res.front_level;
      rear_write  <= res.rear_write;
      rear_level  <= res.rear_level;
      active      <= res.active;
    end
  end

  // A held transaction with a stalled result must block new input.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !out_ready) |-> !in_ready)
    else $error("input accepted while the pipeline was full");

  // A start transaction writes no lamp and keeps the timer running.
  a_start_result: assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_opcode == lbes_pkg::OP_START) |=>
      (out_valid && !front_write && !rear_write && active))
    else $error("start transaction gave a lamp write or an inactive result");

  // A lamp level is only ever high together with its write strobe.
  a_level_needs_write: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((!front_level || front_write) && (!rear_level || rear_write)))
    else $error("lamp level set without a write");

  // An inactive tick result leaves the sequencer fully idle.
  a_inactive_idle: assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_opcode == lbes_pkg::OP_TICK && !res.active) |=>
      (state.effect_mode == lbes_pkg::EFF_NONE && state.remaining_count == 16'd0))
    else $error("timer reported inactive with an effect still pending");

endmodule

@@ test/lbes_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// lbes_tb_pkg: register map and spare codes for the sequencer testbench
// Configuration register indexes shared by the stimulus and the checker, and
// the codes outside the named effects and light modes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package lbes_tb_pkg;

  typedef enum logic [2:0] {
    REG_LIGHT_MODE  = 3'd0,
    REG_FRONT_STATE = 3'd1,
    REG_REAR_STATE  = 3'd2,
    REG_TICK_MS     = 3'd3,
    REG_FAST_PERIOD = 3'd4,
    REG_SLOW_PERIOD = 3'd5,
    REG_HOLD_TICKS  = 3'd6,
    REG_UNMAPPED    = 3'd7
  } reg_index_t;

  // Light modes at and above this value react to nothing.
  localparam logic [2:0] LM_OTHER = 3'd4;
  localparam logic [2:0] LM_TOP   = 3'd7;

  // Highest effect code; codes above EFF_NORMAL behave like no effect.
  localparam logic [2:0] EFF_TOP = 3'd7;

endpackage

@@ test/lbes_checker.sv @@
// ----------------------------------------------------------------------------
// lbes_checker: scoreboard for the lamp effect sequencer
// Tracks configuration writes and input transactions, predicts the lamp
// result of each one and compares it with the results the block returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module lbes_checker
  import lbes_pkg::*;
  import lbes_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        opcode,
  input  logic [2:0]  effect,
  input  logic [15:0] blink_count,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        front_write,
  input  logic        front_level,
  input  logic        rear_write,
  input  logic        rear_level,
  input  logic        active,
  output int unsigned pending,
  output int unsigned errors
);

  cfg_t        regs;
  seq_state_t  seq;
  result_t     lamp_q[$];
  int unsigned err_cnt = 0;

  initial begin
    pending = 0;
    errors  = 0;
  end

  function automatic result_t lamps_written(input logic front_on, input logic rear_on);
    result_t r;
    r = '0;
    r.front_write = 1'b1;
    r.front_level = front_on;
    r.rear_write  = 1'b1;
    r.rear_level  = rear_on;
    return r;
  endfunction

  // Adds one tick to the elapsed time, saturating, and reports whether the
  // phase length has been reached.
  function automatic logic phase_done(input logic [15:0] period);
    logic [17:0] sum;
    sum = {1'b0, seq.elapsed_ms} + {2'b00, regs.tick_ms};
    seq.elapsed_ms = (sum > {1'b0, ELAPSED_MAX}) ? ELAPSED_MAX : sum[16:0];
    return seq.elapsed_ms >= {1'b0, period};
  endfunction

  function automatic result_t manual_restore();
    result_t r;
    r = '0;
    if (regs.light_mode == LM_MANUAL) begin
      if (regs.front_state) begin
        r.front_write = 1'b1;
        r.front_level = 1'b1;
      end
      if (regs.rear_state) begin
        r.rear_write = 1'b1;
        r.rear_level = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic result_t mode_blink_lamps();
    logic man;
    man = (regs.light_mode == LM_MANUAL);
    if ((man && regs.front_state && !regs.rear_state) || regs.light_mode == LM_FRONT)
      return lamps_written(1'b1, 1'b0);
    if ((man && !regs.front_state && regs.rear_state) || regs.light_mode == LM_REAR)
      return lamps_written(1'b0, 1'b1);
    if ((man && regs.front_state && regs.rear_state) || regs.light_mode == LM_BOTH)
      return lamps_written(1'b1, 1'b1);
    return '0;
  endfunction

  function automatic void stop_effect();
    seq.effect_mode = EFF_NONE;
    seq.elapsed_ms  = '0;
  endfunction

  // Advances the sequencer copy by one transaction and returns its lamp result.
  function automatic result_t next_lamp_result(input logic op, input logic [2:0] eff,
                                               input logic [15:0] cnt);
    result_t     r;
    logic [15:0] period;
    logic        blink;
    r = '0;
    if (op == OP_START) begin
      seq.effect_mode     = eff;
      seq.remaining_count = cnt;
      seq.elapsed_ms      = '0;
      r.active            = 1'b1;
      return r;
    end
    if (seq.remaining_count != 0) begin
      period = '0;
      blink  = 1'b1;
      case (seq.effect_mode)
        EFF_FAST, EFF_MODEB: period = regs.fast_period_ms;
        EFF_SLOW:            period = regs.slow_period_ms;
        EFF_DELAY: begin
          blink = 1'b0;
          if (phase_done(regs.tick_ms)) begin
            seq.remaining_count = seq.remaining_count - 16'd1;
            seq.elapsed_ms      = '0;
          end
        end
        default: blink = 1'b0;
      endcase
      if (blink && phase_done(period)) begin
        if (seq.remaining_count[0]) begin
          if (seq.effect_mode == EFF_MODEB) r = mode_blink_lamps();
          else r = lamps_written(1'b0, 1'b1);
        end else begin
          r = lamps_written(1'b0, 1'b0);
        end
        seq.remaining_count = seq.remaining_count - 16'd1;
        seq.elapsed_ms      = '0;
      end
    end else begin
      case (seq.effect_mode)
        EFF_FAST: begin
          if (phase_done(regs.fast_period_ms)) begin
            r = manual_restore();
            stop_effect();
          end
        end
        EFF_SLOW: begin
          if (phase_done(regs.slow_period_ms)) begin
            r = lamps_written(1'b0, 1'b1);
            stop_effect();
          end
        end
        EFF_MODEB: begin
          if (phase_done(regs.fast_period_ms)) begin
            if (regs.light_mode == LM_MANUAL) begin
              r = manual_restore();
              stop_effect();
            end else if (regs.light_mode == LM_FRONT || regs.light_mode == LM_REAR ||
                         regs.light_mode == LM_BOTH) begin
              // React modes hand the lamps over to a delayed-light hold.
              seq.remaining_count = regs.hold_ticks;
              seq.elapsed_ms      = '0;
              seq.effect_mode     = EFF_DELAY;
            end else begin
              stop_effect();
            end
          end
        end
        EFF_DELAY: begin
          r = lamps_written(1'b0, 1'b0);
          stop_effect();
        end
        EFF_NORMAL: seq.effect_mode = EFF_NONE;
        default: ;
      endcase
    end
    r.active = !(seq.effect_mode == EFF_NONE && seq.remaining_count == 0);
    return r;
  endfunction

  function automatic void check_field(input string name, input logic want, input logic got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      err_cnt++;
    end
  endfunction

  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    if (rst) begin
      regs = '{light_mode: LM_MANUAL, front_state: 1'b0, rear_state: 1'b0,
               tick_ms: 16'd50, fast_period_ms: 16'd200, slow_period_ms: 16'd1000,
               hold_ticks: 16'd100};
      seq  = '0;
      lamp_q.delete();
    end else begin
      // Results leave before new transactions enter, so a result can never be
      // matched against the transaction accepted at the same edge.
      if (out_valid && out_ready) begin
        got = {front_write, front_level, rear_write, rear_level, active};
        if (lamp_q.size() == 0) begin
          $error("result transaction with no expected result waiting");
          err_cnt++;
        end else begin
          want = lamp_q.pop_front();
          check_field("front_write", want.front_write, got.front_write);
          check_field("front_level", want.front_level, got.front_level);
          check_field("rear_write", want.rear_write, got.rear_write);
          check_field("rear_level", want.rear_level, got.rear_level);
          check_field("active", want.active, got.active);
        end
      end
      if (cfg_we) begin
        case (reg_index_t'(cfg_index))
          REG_LIGHT_MODE:  regs.light_mode     = cfg_data[2:0];
          REG_FRONT_STATE: regs.front_state    = cfg_data[0];
          REG_REAR_STATE:  regs.rear_state     = cfg_data[0];
          REG_TICK_MS:     regs.tick_ms        = cfg_data;
          REG_FAST_PERIOD: regs.fast_period_ms = cfg_data;
          REG_SLOW_PERIOD: regs.slow_period_ms = cfg_data;
          REG_HOLD_TICKS:  regs.hold_ticks     = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) lamp_q.push_back(next_lamp_result(opcode, effect, blink_count));
    end
    pending <= lamp_q.size();
    errors  <= err_cnt;
  end

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb: testbench for the lamp effect sequencer
// Runs random start and tick sequences at the reset values, then a directed
// sweep of every effect and its end-of-count behavior, then random sequences
// under several register settings, with bursty input traffic and a stalling
// receiver. A checker module predicts each result and reports mismatches.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
  import lbes_pkg::*;
  import lbes_tb_pkg::*;

  // Cycles to wait after the last expected result before a register write or
  // the verdict.
  localparam int DRAIN_CYCLES = 8;

  // All block inputs start at known values; reset is held from time zero.
  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        cfg_we      = 1'b0;
  logic [2:0]  cfg_index   = '0;
  logic [15:0] cfg_data    = '0;
  logic        in_valid    = 1'b0;
  logic        opcode      = OP_TICK;
  logic [2:0]  effect      = EFF_NONE;
  logic [15:0] blink_count = '0;
  logic        out_ready   = 1'b1;

  logic        in_ready;
  logic        out_valid;
  logic        front_write;
  logic        front_level;
  logic        rear_write;
  logic        rear_level;
  logic        active;

  int unsigned pending;
  int unsigned errors;

  // Transactions left in the current sender burst.
  int unsigned burst_left = 0;

  always #5 clk = ~clk;

  led_blink_effect_sequencer_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .effect      (effect),
    .blink_count (blink_count),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .front_write (front_write),
    .front_level (front_level),
    .rear_write  (rear_write),
    .rear_level  (rear_level),
    .active      (active)
  );

  lbes_checker i_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .effect      (effect),
    .blink_count (blink_count),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .front_write (front_write),
    .front_level (front_level),
    .rear_write  (rear_write),
    .rear_level  (rear_level),
    .active      (active),
    .pending     (pending),
    .errors      (errors)
  );

  // The receiver switches between behaviors, each held for a random stretch: always
  // ready, a coin toss, mostly stalled, and rarely stalled. The steady stretches
  // give runs with no back-pressure at all.
  typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_SPARSE, RX_RARE_STALL} rx_mode_t;

  rx_mode_t    rx_mode = RX_STEADY;
  int unsigned rx_left = 0;

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(16, 160);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_STEADY:     out_ready <= 1'b1;
      RX_COIN:       out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE:     out_ready <= ($urandom_range(0, 3) == 0);
      default:       out_ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Presents one input transaction and returns at the edge where it is taken.
  // Between bursts the valid drops for a random gap; a gap of zero keeps valid
  // high so back-to-back bursts run without a bubble.
  task automatic send_item(input logic op, input logic [2:0] eff, input logic [15:0] cnt);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    effect      <= eff;
    blink_count <= cnt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
  endtask

  // Stops the input side and waits until every expected result has come back.
  task automatic drain();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Writes every register. The one-bit and three-bit registers get random
  // junk in the unused data bits, which the block must drop.
  task automatic set_config(input logic [2:0] lm, input logic fs, input logic rs,
                            input logic [15:0] tick, input logic [15:0] fast,
                            input logic [15:0] slow, input logic [15:0] hold);
    logic [15:0] junk;
    junk = 16'($urandom());
    write_reg(REG_LIGHT_MODE, {junk[15:3], lm});
    junk = 16'($urandom());
    write_reg(REG_FRONT_STATE, {junk[15:1], fs});
    junk = 16'($urandom());
    write_reg(REG_REAR_STATE, {junk[15:1], rs});
    write_reg(REG_TICK_MS, tick);
    write_reg(REG_FAST_PERIOD, fast);
    write_reg(REG_SLOW_PERIOD, slow);
    write_reg(REG_HOLD_TICKS, hold);
  endtask

  function automatic logic [2:0] pick_effect();
    if ($urandom_range(0, 99) < 85) return 3'($urandom_range(EFF_FAST, EFF_NORMAL));
    return 3'($urandom_range(0, EFF_TOP));
  endfunction

  // Mostly short counts so effects run to their end; now and then a long one
  // or a fully random value to toggle every count bit.
  function automatic logic [15:0] pick_count();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 16'($urandom_range(0, 5));
    if (roll < 85) return 16'($urandom_range(6, 40));
    return 16'($urandom());
  endfunction

  // Random traffic: a start transaction followed by a run of ticks, with the
  // occasional stray start dropped in mid-run to break sequences. Ticks carry
  // random effect and count fields, which the block must ignore.
  task automatic random_phase(input int unsigned n);
    int unsigned sent;
    int unsigned nticks;
    sent = 0;
    while (sent < n) begin
      send_item(OP_START, pick_effect(), pick_count());
      sent++;
      nticks = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : $urandom_range(5, 40);
      repeat (nticks) begin
        if ($urandom_range(0, 24) == 0)
          send_item(OP_START, 3'($urandom_range(0, EFF_TOP)), 16'($urandom()));
        else
          send_item(OP_TICK, 3'($urandom_range(0, EFF_TOP)), 16'($urandom()));
        sent++;
      end
    end
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset values of the registers: four ticks per fast phase, twenty per slow.
    random_phase(100);

    // Directed sweep with one tick per fast phase and two per slow phase.
    // Manual mode with only the front lamp wanted on.
    set_config(LM_MANUAL, 1'b1, 1'b0, 16'd100, 16'd100, 16'd200, 16'd2);
    // A tick with no effect and no count leaves the timer stopped.
    send_item(OP_TICK, EFF_NONE, 16'd0);
    // No effect but a full count: ticks change nothing, the timer stays on.
    send_item(OP_START, EFF_NONE, 16'hFFFF);
    send_item(OP_TICK, EFF_NONE, 16'd0);
    // An undefined effect code behaves like no effect.
    send_item(OP_START, EFF_TOP, 16'd1);
    send_item(OP_TICK, EFF_NONE, 16'd0);
    // Fast blink: even phase off, odd phase rear on, then the manual front
    // lamp is restored.
    send_item(OP_START, EFF_FAST, 16'd2);
    repeat (3) send_item(OP_TICK, EFF_NONE, 16'd0);
    // Slow blink: the phase needs two ticks; the end writes front off, rear on.
    send_item(OP_START, EFF_SLOW, 16'd1);
    repeat (4) send_item(OP_TICK, EFF_NONE, 16'd0);
    // Mode blink in manual mode lights the front lamp, then restores it.
    send_item(OP_START, EFF_MODEB, 16'd1);
    repeat (2) send_item(OP_TICK, EFF_NONE, 16'd0);
    // Delayed light counts down silently, then switches both lamps off.
    send_item(OP_START, EFF_DELAY, 16'd1);
    repeat (2) send_item(OP_TICK, EFF_NONE, 16'd0);
    // Normal with no count ends on the first tick.
    send_item(OP_START, EFF_NORMAL, 16'd0);
    send_item(OP_TICK, EFF_NONE, 16'd0);
    drain();

    // React front: mode blink hands over to a short hold.
    set_config(LM_FRONT, 1'b0, 1'b1, 16'd50, 16'd100, 16'd150, 16'd3);
    random_phase(135);

    // React rear with a zero hold, so the handover ends on the next tick.
    set_config(LM_REAR, 1'b1, 1'b1, 16'd30, 16'd60, 16'd90, 16'd0);
    random_phase(135);

    // React both with every wide register at its maximum.
    set_config(LM_BOTH, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_phase(100);

    // Zero tick and zero periods: every phase is reached on its first tick.
    // Light mode four reacts to nothing.
    set_config(LM_OTHER, 1'b0, 1'b1, 16'd0, 16'd0, 16'd0, 16'd1);
    random_phase(100);

    // Manual mode with both lamps wanted, plus a write to the unmapped index,
    // which must leave every register alone.
    set_config(LM_MANUAL, 1'b1, 1'b1, 16'd7, 16'd20, 16'd30, 16'd5);
    write_reg(REG_UNMAPPED, 16'($urandom()));
    random_phase(135);

    // Random small setting, light mode anywhere in its three bits.
    set_config(3'($urandom_range(0, LM_TOP)), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)), 16'($urandom_range(1, 100)),
               16'($urandom_range(1, 300)), 16'($urandom_range(1, 300)),
               16'($urandom_range(0, 8)));
    random_phase(135);

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Safety net against a hung handshake; a correct run ends far sooner.
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
